// ===== rtl/core/biquad_iir_filter_top_macros.svh =====
// Assertion macros shared by the biquad filter RTL.
// Each macro expects i_clk and i_rst_n to be visible in the module that uses it.
`ifndef BIQUAD_IIR_FILTER_TOP_MACROS_SVH
`define BIQUAD_IIR_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/biq_pkg.sv =====
// Shared widths, register indexes, types and datapath commands of the biquad filter.
// No dependencies; every RTL module imports this package.
package biq_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 24;
    localparam int COEF_FRAC_BITS = 22;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = SAMPLE_BITS + COEF_BITS + 2;
    localparam int SUM_BITS       = ACC_BITS + 2;
    localparam int Q_BITS         = SUM_BITS - COEF_FRAC_BITS;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = COEF_BITS;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0     = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B1     = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B2     = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1     = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2     = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_FORM_SELECT = CFG_IDX_BITS'(5);

    // Unity gain in Q2.22.
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    typedef enum logic {
        FORM_DF1  = 1'b0,
        FORM_TDF2 = 1'b1
    } t_form;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coefs;

    // Operand pairs of the shared multiplier.
    typedef enum logic [3:0] {
        MUL_B0_X,
        MUL_B1_XP1,
        MUL_B2_XP2,
        MUL_A1_YP1,
        MUL_A2_YP2,
        MUL_B1_X,
        MUL_B2_X,
        MUL_A1_Y,
        MUL_A2_Y
    } t_mul_sel;

    // What a product is added to when it reaches the accumulator.
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ACC,
        BASE_ACC1,
        BASE_ACC2
    } t_acc_base;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D0,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_D4,
        ST_DDRAIN,
        ST_DROUND,
        ST_T0,
        ST_TWAIT,
        ST_TROUND,
        ST_T3,
        ST_T4,
        ST_T5,
        ST_T6,
        ST_TDRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic      load;       // latch the input sample, clear history on restart
        logic      mul_en;     // issue a product this cycle
        t_mul_sel  mul_sel;
        t_acc_base base;
        logic      wr_acc1;    // product lands as the new accum_one
        logic      wr_acc2;    // product lands as the new accum_two
        logic      round;      // round and saturate the accumulator into y
        logic      shift_df1;  // shift direct form 1 history with the new y
        logic      out_load;   // move y into the output register
    } t_dp_cmd;

endpackage

// ===== rtl/core/biq_dp.sv =====
// Datapath of the biquad filter: history, shared multiplier, accumulator, rounding.
// Depends on biq_pkg; driven by biq_ctrl through a t_dp_cmd command word.
module biq_dp
    import biq_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  t_coefs                        i_coefs,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_clipped
);

    localparam int ACC_EXT  = SUM_BITS - ACC_BITS;
    localparam int PROD_EXT = SUM_BITS - PROD_BITS;
    localparam logic signed [SUM_BITS-1:0] HALF_LSB = SUM_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_x, r_xp1, r_xp2, r_yp1, r_yp2, r_y;
    logic signed [ACC_BITS-1:0]    r_acc1, r_acc2;
    logic signed [SUM_BITS-1:0]    r_acc;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic                          r_pv, r_pneg, r_pwr1, r_pwr2;
    t_acc_base                     r_pbase;
    logic                          r_clip;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_clip;

    logic signed [COEF_BITS-1:0]   w_coef;
    logic signed [SAMPLE_BITS-1:0] w_dat;
    logic                          w_neg;
    logic signed [PROD_BITS-1:0]   n_prod;
    logic signed [SUM_BITS-1:0]    w_base, w_pext, w_acc_sum;
    logic signed [SUM_BITS-1:0]    w_rsum;
    logic signed [Q_BITS-1:0]      w_q;
    logic                          w_ovf;
    logic signed [SAMPLE_BITS-1:0] n_y;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_B0_X:   begin w_coef = i_coefs.b0; w_dat = r_x;   w_neg = 1'b0; end
            MUL_B1_XP1: begin w_coef = i_coefs.b1; w_dat = r_xp1; w_neg = 1'b0; end
            MUL_B2_XP2: begin w_coef = i_coefs.b2; w_dat = r_xp2; w_neg = 1'b0; end
            MUL_A1_YP1: begin w_coef = i_coefs.a1; w_dat = r_yp1; w_neg = 1'b1; end
            MUL_A2_YP2: begin w_coef = i_coefs.a2; w_dat = r_yp2; w_neg = 1'b1; end
            MUL_B1_X:   begin w_coef = i_coefs.b1; w_dat = r_x;   w_neg = 1'b0; end
            MUL_B2_X:   begin w_coef = i_coefs.b2; w_dat = r_x;   w_neg = 1'b0; end
            MUL_A1_Y:   begin w_coef = i_coefs.a1; w_dat = r_y;   w_neg = 1'b1; end
            MUL_A2_Y:   begin w_coef = i_coefs.a2; w_dat = r_y;   w_neg = 1'b1; end
            default:    begin w_coef = '0;         w_dat = '0;    w_neg = 1'b0; end
        endcase
    end

    assign n_prod = PROD_BITS'(w_coef * w_dat);

    // The accumulator needs no saturation: five 16 x 24 bit products stay far below
    // the working width, and the stored accumulators stay inside 42 bits.
    always_comb begin
        unique case (r_pbase)
            BASE_ZERO: w_base = '0;
            BASE_ACC:  w_base = r_acc;
            BASE_ACC1: w_base = {{ACC_EXT{r_acc1[ACC_BITS-1]}}, r_acc1};
            BASE_ACC2: w_base = {{ACC_EXT{r_acc2[ACC_BITS-1]}}, r_acc2};
            default:   w_base = '0;
        endcase
    end

    assign w_pext    = {{PROD_EXT{r_prod[PROD_BITS-1]}}, r_prod};
    assign w_acc_sum = r_pneg ? (w_base - w_pext) : (w_base + w_pext);

    // Round half up, then take the integer part by dropping the fraction bits.
    assign w_rsum = r_acc + HALF_LSB;
    assign w_q    = w_rsum[SUM_BITS-1:COEF_FRAC_BITS];
    assign w_ovf  = (w_q[Q_BITS-1:SAMPLE_BITS-1] != {(Q_BITS-SAMPLE_BITS+1){1'b0}})
                 && (w_q[Q_BITS-1:SAMPLE_BITS-1] != {(Q_BITS-SAMPLE_BITS+1){1'b1}});
    assign n_y    = w_ovf ? (w_q[Q_BITS-1] ? Y_MIN : Y_MAX) : w_q[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xp1  <= '0;
            r_xp2  <= '0;
            r_yp1  <= '0;
            r_yp2  <= '0;
            r_acc1 <= '0;
            r_acc2 <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
            if (i_cmd.load && i_restart) begin
                r_xp1  <= '0;
                r_xp2  <= '0;
                r_yp1  <= '0;
                r_yp2  <= '0;
                r_acc1 <= '0;
                r_acc2 <= '0;
            end
            if (r_pv && r_pwr1) begin
                r_acc1 <= w_acc_sum[ACC_BITS-1:0];
            end
            if (r_pv && r_pwr2) begin
                r_acc2 <= w_acc_sum[ACC_BITS-1:0];
            end
            if (i_cmd.round && i_cmd.shift_df1) begin
                r_xp2 <= r_xp1;
                r_xp1 <= r_x;
                r_yp2 <= r_yp1;
                r_yp1 <= n_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample;
        end
        if (i_cmd.mul_en) begin
            r_prod  <= n_prod;
            r_pneg  <= w_neg;
            r_pbase <= i_cmd.base;
            r_pwr1  <= i_cmd.wr_acc1;
            r_pwr2  <= i_cmd.wr_acc2;
        end
        if (r_pv) begin
            r_acc <= w_acc_sum;
        end
        if (i_cmd.round) begin
            r_y    <= n_y;
            r_clip <= w_ovf;
        end
        if (i_cmd.out_load) begin
            r_out_sample <= r_y;
            r_out_clip   <= r_clip;
        end
    end

    assign o_sample  = r_out_sample;
    assign o_clipped = r_out_clip;

endmodule

// ===== rtl/core/biq_ctrl.sv =====
// Sequencer of the biquad filter: handshakes and the per-form multiply schedule.
// Depends on biq_pkg and biquad_iir_filter_top_macros.svh; commands biq_dp.
`include "biquad_iir_filter_top_macros.svh"

module biq_ctrl
    import biq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_form   i_form,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    w_accept, w_slot_free;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_m_tready;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_B0_X;
        o_cmd.base    = BASE_ZERO;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_form == FORM_TDF2) ? ST_T0 : ST_D0;
                end
            end
            // Direct form 1: five products summed, then one rounding step.
            ST_D0: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_B0_X; o_cmd.base = BASE_ZERO;
                n_state = ST_D1;
            end
            ST_D1: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_B1_XP1; o_cmd.base = BASE_ACC;
                n_state = ST_D2;
            end
            ST_D2: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_B2_XP2; o_cmd.base = BASE_ACC;
                n_state = ST_D3;
            end
            ST_D3: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_A1_YP1; o_cmd.base = BASE_ACC;
                n_state = ST_D4;
            end
            ST_D4: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_A2_YP2; o_cmd.base = BASE_ACC;
                n_state = ST_DDRAIN;
            end
            ST_DDRAIN: begin
                n_state = ST_DROUND;
            end
            ST_DROUND: begin
                o_cmd.round     = 1'b1;
                o_cmd.shift_df1 = 1'b1;
                n_state         = ST_DONE;
            end
            // Transposed form 2: y first, then both accumulators from x and y.
            ST_T0: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_B0_X; o_cmd.base = BASE_ACC1;
                n_state = ST_TWAIT;
            end
            ST_TWAIT: begin
                n_state = ST_TROUND;
            end
            ST_TROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_T3;
            end
            ST_T3: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_B1_X; o_cmd.base = BASE_ACC2;
                n_state = ST_T4;
            end
            ST_T4: begin
                o_cmd.mul_en  = 1'b1; o_cmd.mul_sel = MUL_A1_Y; o_cmd.base = BASE_ACC;
                o_cmd.wr_acc1 = 1'b1;
                n_state = ST_T5;
            end
            ST_T5: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MUL_B2_X; o_cmd.base = BASE_ZERO;
                n_state = ST_T6;
            end
            ST_T6: begin
                o_cmd.mul_en  = 1'b1; o_cmd.mul_sel = MUL_A2_Y; o_cmd.base = BASE_ACC;
                o_cmd.wr_acc2 = 1'b1;
                n_state = ST_TDRAIN;
            end
            ST_TDRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `BIQ_ASSERT_NEXT(a_busy_after_accept, w_accept, (r_state != ST_IDLE), "idle right after accepting a sample")
    `BIQ_ASSERT_NEXT(a_one_at_a_time, w_accept, !o_s_tready, "second sample taken while one is in work")
    `BIQ_ASSERT_SAME(a_no_overwrite, o_cmd.out_load, (!r_out_valid || i_m_tready), "output overwritten before it was taken")

endmodule

// ===== rtl/core/biquad_iir_filter_top.sv =====
// Biquad IIR section, top level: configuration registers and stream ports.
// Depends on biq_pkg, biq_ctrl and biq_dp.
//
// One 16-bit sample in gives one rounded, saturated 16-bit sample out, with a clip
// flag. All five products share a single 16 x 24 bit multiplier with a registered
// product, so a new sample is accepted only after the last one has run through its
// multiply schedule in direct form 1 or transposed direct form 2; a result not yet
// taken holds the next one back only at its end. Coefficient and form writes keep
// the filter history; tuser bit restart clears it.
module biquad_iir_filter_top
    import biq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [15:0]              s_axis_tdata,   // [15:0] sample_in
    input  logic [0:0]               s_axis_tuser,   // [0] restart
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]               m_axis_tuser,   // [0] clipped
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_coefs  r_coefs;
    t_form   r_form;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_ONE;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
            r_form     <= FORM_DF1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_COEF_B0:     r_coefs.b0 <= i_cfg_wdata[COEF_BITS-1:0];
                REG_COEF_B1:     r_coefs.b1 <= i_cfg_wdata[COEF_BITS-1:0];
                REG_COEF_B2:     r_coefs.b2 <= i_cfg_wdata[COEF_BITS-1:0];
                REG_COEF_A1:     r_coefs.a1 <= i_cfg_wdata[COEF_BITS-1:0];
                REG_COEF_A2:     r_coefs.a2 <= i_cfg_wdata[COEF_BITS-1:0];
                REG_FORM_SELECT: r_form     <= t_form'(i_cfg_wdata[0]);
                default: begin
                end
            endcase
        end
    end

    biq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_form     (r_form),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    biq_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_coefs   (r_coefs),
        .i_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_restart (s_axis_tuser[0]),
        .o_sample  (m_axis_tdata[SAMPLE_BITS-1:0]),
        .o_clipped (m_axis_tuser[0])
    );

endmodule
